>>> hdl/ddf_pkg.sv
`default_nettype none

package ddf_pkg;

    localparam int ValueWidth  = 32;
    localparam int BcdDigits   = 10;
    localparam int StepCount   = ValueWidth;
    localparam int CountWidth  = $clog2(StepCount);

    localparam logic [3:0] SYM_BLANK = 4'd10;
    localparam logic [3:0] SYM_DASH  = 4'd11;
    localparam logic [3:0] SYM_O     = 4'd12;
    localparam logic [3:0] SYM_L     = 4'd13;
    localparam logic [3:0] POINT_BASE = 4'b1000;

    typedef logic [BcdDigits-1:0][3:0] bcd_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  point_position;
        logic [3:0]  dot_enable;
    } item_t;

    typedef struct packed {
        logic [3:0] digit0_symbol;
        logic [3:0] digit1_symbol;
        logic [3:0] digit2_symbol;
        logic [3:0] digit3_symbol;
        logic [3:0] dot_pattern;
        logic       overload;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
    } conv_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/ddf_dabble.sv
`default_nettype none

module ddf_dabble (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire ddf_pkg::conv_ctrl_t                   ctrl,
    input  wire logic [ddf_pkg::ValueWidth-1:0]        value,
    output ddf_pkg::bcd_t                              digits,
    output logic                                       last
);

    logic [ddf_pkg::ValueWidth-1:0]    bin_reg;
    logic [ddf_pkg::ValueWidth-1:0]    bin_next;
    ddf_pkg::bcd_t                     bcd_reg;
    ddf_pkg::bcd_t                     bcd_next;
    ddf_pkg::bcd_t                     bcd_adj;
    logic [ddf_pkg::BcdDigits*4-1:0]   adj_bits;
    logic [ddf_pkg::CountWidth-1:0]    count_reg;
    logic [ddf_pkg::CountWidth-1:0]    count_next;

    // One shift-and-add-3 step: correct every digit, then shift one bit in.
    always_comb
    begin
        for (int i = 0; i < ddf_pkg::BcdDigits; i++)
        begin
            bcd_adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
    end

    assign adj_bits = bcd_adj;

    always_comb
    begin
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        if (ctrl.load)
        begin
            bin_next   = value;
            bcd_next   = '0;
            count_next = '0;
        end
        else if (ctrl.step)
        begin
            bin_next   = {bin_reg[ddf_pkg::ValueWidth-2:0], 1'b0};
            bcd_next   = {adj_bits[ddf_pkg::BcdDigits*4-2:0], bin_reg[ddf_pkg::ValueWidth-1]};
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign digits = bcd_reg;
    assign last   = (count_reg == ddf_pkg::CountWidth'(ddf_pkg::StepCount - 1));

endmodule

`default_nettype wire

>>> hdl/ddf_format.sv
`default_nettype none

module ddf_format (
    input  wire ddf_pkg::bcd_t   digits,
    input  wire logic [2:0]      point_position,
    input  wire logic [3:0]      dot_enable,
    output ddf_pkg::result_t     result
);

    logic [3:0] hi;
    logic [3:0] k1;
    logic [3:0] k2;
    logic [3:0] k3;
    logic       small_value;
    logic [2:0] dropped;
    logic [2:0] shift;
    logic [3:0] s0;
    logic [3:0] s1;
    logic [3:0] s2;
    logic [3:0] s3;

    // Index of the most significant nonzero digit, zero for a zero value.
    always_comb
    begin
        hi = '0;
        for (int i = 1; i < ddf_pkg::BcdDigits; i++)
        begin
            if (digits[i] != 4'd0)
            begin
                hi = 4'(i);
            end
        end
    end

    assign small_value = (hi < 4'd3);
    assign k1          = hi - 4'd1;
    assign k2          = hi - 4'd2;
    assign k3          = hi - 4'd3;
    assign dropped     = small_value ? 3'd0 : k3[2:0];
    assign shift       = point_position - dropped;

    always_comb
    begin
        if (small_value)
        begin
            s0 = ddf_pkg::SYM_BLANK;
            s1 = digits[2];
            s2 = digits[1];
            s3 = digits[0];
            if (point_position == 3'd0 && digits[2] == 4'd0)
            begin
                s1 = ddf_pkg::SYM_BLANK;
                if (digits[1] == 4'd0)
                begin
                    s2 = ddf_pkg::SYM_BLANK;
                end
            end
        end
        else
        begin
            s0 = digits[hi];
            s1 = digits[k1];
            s2 = digits[k2];
            s3 = digits[k3];
        end
    end

    always_comb
    begin
        if (dropped > point_position)
        begin
            result.digit0_symbol = ddf_pkg::SYM_DASH;
            result.digit1_symbol = ddf_pkg::SYM_O;
            result.digit2_symbol = ddf_pkg::SYM_L;
            result.digit3_symbol = ddf_pkg::SYM_DASH;
            result.dot_pattern   = 4'd0;
            result.overload      = 1'b1;
        end
        else
        begin
            result.digit0_symbol = s0;
            result.digit1_symbol = s1;
            result.digit2_symbol = s2;
            result.digit3_symbol = s3;
            result.dot_pattern   = (ddf_pkg::POINT_BASE >> shift) & dot_enable;
            result.overload      = 1'b0;
        end
    end

endmodule

`default_nettype wire

>>> hdl/decimal_display_formatter.sv
// A word is loaded, stepped in ST_CONVERT and formatted in ST_DONE, which
// writes the output register once it is free. A new word is taken only in
// ST_IDLE, after the 32 shift-and-add-3 steps of the shared unit and ST_DONE.
// A finished result waits in its output register while the next word is taken.
// Reset clears the sequencer, the step counter and the output valid flag.
`default_nettype none

module decimal_display_formatter (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire ddf_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output ddf_pkg::result_t      result
);

    ddf_pkg::state_t     state_reg;
    ddf_pkg::state_t     state_next;
    ddf_pkg::conv_ctrl_t ctrl;
    ddf_pkg::bcd_t       digits;
    ddf_pkg::result_t    formatted;
    ddf_pkg::result_t    result_reg;
    logic                result_valid_reg;
    logic                result_valid_next;
    logic                last;
    logic                out_free;
    logic                out_load;
    logic [2:0]          pos_reg;
    logic [3:0]          mask_reg;

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ddf_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ddf_pkg::ST_CONVERT;
                end
            end
            ddf_pkg::ST_CONVERT:
            begin
                if (last)
                begin
                    state_next = ddf_pkg::ST_DONE;
                end
            end
            ddf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ddf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ddf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        item_stall = 1'b1;
        ctrl.load  = 1'b0;
        ctrl.step  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ddf_pkg::ST_IDLE:
            begin
                item_stall = 1'b0;
                ctrl.load  = item_valid;
            end
            ddf_pkg::ST_CONVERT:
            begin
                ctrl.step = 1'b1;
            end
            ddf_pkg::ST_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    ddf_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .value  (item.value),
        .digits (digits),
        .last   (last)
    );

    ddf_format u_format (
        .digits         (digits),
        .point_position (pos_reg),
        .dot_enable     (mask_reg),
        .result         (formatted)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ddf_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pos_reg  <= item.point_position;
            mask_reg <= item.dot_enable;
        end
        if (out_load)
        begin
            result_reg <= formatted;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ddf_pkg::ST_DONE))
        else $error("result became valid outside the done state");

    a_overload_no_dots: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.overload) |-> (result_reg.dot_pattern == 4'd0))
        else $error("overload result carries dots");

    a_normal_symbols: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.overload) |->
            (result_reg.digit0_symbol <= ddf_pkg::SYM_BLANK &&
             result_reg.digit3_symbol < ddf_pkg::SYM_BLANK))
        else $error("normal result holds an overload symbol");

    a_done_after_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ddf_pkg::ST_CONVERT && !last) |=> (state_reg == ddf_pkg::ST_CONVERT))
        else $error("conversion left before the last step");

endmodule

`default_nettype wire

>>> verif/decimal_display_formatter_tb.sv
module decimal_display_formatter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClockHalf      = 5;
    localparam int ResetCycles    = 12;
    localparam int RandomWords    = 450;
    localparam int SettleCycles   = 80;
    localparam int CycleLimit     = 400000;
    localparam int LongHoldStart  = 2500;
    localparam int LongHoldCycles = 600;
    localparam longint unsigned SmallLimit = 1000;
    localparam longint unsigned TopLimit   = 10000;

    typedef struct {
        ddf_pkg::item_t word;
        bit             drain_first;
    } pending_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_RUNS
    } stall_mode_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    ddf_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    ddf_pkg::result_t result;

    pending_t         pending_words[$];
    ddf_pkg::result_t expected_displays[$];
    int       error_count = 0;
    int       cycle_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       rx_cycles = 0;
    int       hold_left = 0;
    int       mode_left = 0;
    int       run_left = 0;
    stall_mode_t rx_mode = STALL_NONE;

    decimal_display_formatter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #ClockHalf clk = 1'b1;
        #ClockHalf clk = 1'b0;
    end

    function automatic ddf_pkg::result_t format_display(ddf_pkg::item_t w);
        ddf_pkg::result_t r;
        logic [3:0]       sym [4];
        longint unsigned  v;
        longint unsigned  top;
        int               dropped;
        int               pos;
        v = w.value;
        pos = w.point_position;
        dropped = 0;
        if (v < SmallLimit)
        begin
            sym[0] = ddf_pkg::SYM_BLANK;
            sym[1] = 4'(v / 100);
            sym[2] = 4'((v / 10) % 10);
            sym[3] = 4'(v % 10);
            if (pos == 0 && sym[1] == 4'd0)
            begin
                sym[1] = ddf_pkg::SYM_BLANK;
                if (sym[2] == 4'd0)
                    sym[2] = ddf_pkg::SYM_BLANK;
            end
        end
        else
        begin
            top = v;
            while (top >= TopLimit)
            begin
                top = top / 10;
                dropped++;
            end
            sym[0] = 4'(top / 1000);
            sym[1] = 4'((top / 100) % 10);
            sym[2] = 4'((top / 10) % 10);
            sym[3] = 4'(top % 10);
        end
        if (dropped > pos)
        begin
            r.digit0_symbol = ddf_pkg::SYM_DASH;
            r.digit1_symbol = ddf_pkg::SYM_O;
            r.digit2_symbol = ddf_pkg::SYM_L;
            r.digit3_symbol = ddf_pkg::SYM_DASH;
            r.dot_pattern   = 4'd0;
            r.overload      = 1'b1;
        end
        else
        begin
            r.digit0_symbol = sym[0];
            r.digit1_symbol = sym[1];
            r.digit2_symbol = sym[2];
            r.digit3_symbol = sym[3];
            r.dot_pattern   = (ddf_pkg::POINT_BASE >> (pos - dropped)) & w.dot_enable;
            r.overload      = 1'b0;
        end
        return r;
    endfunction

    task automatic queue_word(input logic [31:0] value, input int pos, input int mask,
                              input bit drain_first);
        pending_t p;
        p.word.value = value;
        p.word.point_position = 3'(pos);
        p.word.dot_enable = 4'(mask);
        p.drain_first = drain_first;
        pending_words.push_back(p);
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            error_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && !item_stall)
                expected_displays.push_back(format_display(item));
            if (!item_valid || !item_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (pending_words.size() == 0)
                    item_valid <= 1'b0;
                else if (pending_words[0].drain_first && expected_displays.size() != 0)
                    item_valid <= 1'b0;
                else
                begin
                    item <= pending_words.pop_front().word;
                    item_valid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = $urandom_range(35, 120);
                        else
                            gap_left = $urandom_range(0, 20);
                    end
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            rx_cycles++;
            if (rx_cycles == LongHoldStart)
                hold_left = LongHoldCycles;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    rx_mode = stall_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(50, 400);
                end
                mode_left--;
                case (rx_mode)
                    STALL_NONE:
                        result_stall <= 1'b0;
                    STALL_RANDOM:
                        result_stall <= ($urandom_range(0, 2) == 0);
                    default:
                    begin
                        if (run_left > 0)
                        begin
                            run_left--;
                            result_stall <= 1'b1;
                        end
                        else if ($urandom_range(0, 9) == 0)
                        begin
                            run_left = $urandom_range(1, 40);
                            result_stall <= 1'b1;
                        end
                        else
                            result_stall <= 1'b0;
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_displays.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual %h", $time, result);
            end
            else
            begin
                ddf_pkg::result_t want;
                want = expected_displays.pop_front();
                check_field("digit0_symbol", want.digit0_symbol, result.digit0_symbol);
                check_field("digit1_symbol", want.digit1_symbol, result.digit1_symbol);
                check_field("digit2_symbol", want.digit2_symbol, result.digit2_symbol);
                check_field("digit3_symbol", want.digit3_symbol, result.digit3_symbol);
                check_field("dot_pattern", want.dot_pattern, result.dot_pattern);
                check_field("overload", want.overload, result.overload);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        longint unsigned lo;
        longint unsigned hi;
        int              ndig;
        logic [31:0]     v;

        queue_word(32'd0, 0, 15, 1'b0);
        queue_word(32'd0, 3, 15, 1'b0);
        queue_word(32'd1, 0, 15, 1'b0);
        queue_word(32'd10, 0, 15, 1'b0);
        queue_word(32'd100, 0, 15, 1'b0);
        queue_word(32'd999, 0, 0, 1'b0);
        queue_word(32'd5, 1, 15, 1'b0);
        queue_word(32'd42, 2, 4, 1'b0);
        queue_word(32'd7, 4, 15, 1'b0);
        queue_word(32'd1000, 3, 1, 1'b0);
        queue_word(32'd9999, 0, 15, 1'b0);
        queue_word(32'd1234, 7, 15, 1'b0);
        queue_word(32'd10000, 0, 15, 1'b0);
        queue_word(32'd10000, 1, 15, 1'b0);
        queue_word(32'd12345678, 4, 15, 1'b0);
        queue_word(32'd12345678, 5, 2, 1'b0);
        queue_word(32'd1000000000, 7, 15, 1'b0);
        queue_word(32'hFFFF_FFFF, 6, 15, 1'b0);
        queue_word(32'hFFFF_FFFF, 5, 15, 1'b0);
        queue_word(32'hFFFF_FFFF, 0, 0, 1'b0);
        queue_word(32'h8000_0000, 7, 8, 1'b0);
        queue_word(32'd99999, 2, 6, 1'b1);

        for (int n = 0; n < RandomWords; n++)
        begin
            if ($urandom_range(0, 3) == 0)
                v = $urandom;
            else
            begin
                ndig = $urandom_range(1, 10);
                lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
                hi = 64'd10 ** ndig - 1;
                if (hi > 64'hFFFF_FFFF)
                    hi = 64'hFFFF_FFFF;
                v = 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
            end
            queue_word(v, $urandom_range(0, 7), $urandom_range(0, 15),
                       $urandom_range(0, 60) == 0);
        end

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_words.size() != 0 || item_valid || expected_displays.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(posedge clk);

        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
hdl/ddf_pkg.sv
hdl/ddf_dabble.sv
hdl/ddf_format.sv
hdl/decimal_display_formatter.sv
verif/decimal_display_formatter_tb.sv
